// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Holds the command and status codes, the data type and the per-cell control
// struct that the top level hands to each cell.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int unsigned DataW  = 32;
   localparam int unsigned CountW = 5;

   typedef logic signed [DataW-1:0] data_type;
   typedef logic [CountW-1:0]       count_type;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // per-cell control for one cycle
   typedef struct packed {
      logic ins;       // an insert that is taken this cycle while the queue is not full
      logic rem;       // a remove that is taken this cycle while the queue is not empty
      logic occupied;  // cell index is below the entry count
      logic ge_prev;   // left neighbor yields its place to the new word
   } cell_ctl_type;

endpackage

// ===== rtl/core/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if: valid/ready channels of the sorted priority queue
// Request channel carries a command and a value, response channel carries
// status, removed value and entry count.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic             valid;
   logic             ready;
   spq_pkg::cmd_type cmd;
   logic signed [31:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface spq_rsp_if;
   logic                valid;
   logic                ready;
   spq_pkg::status_type status;
   logic signed [31:0]  removed_value;
   logic [4:0]          count;

   modport source (output valid, output status, output removed_value, output count,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input count,
                   output ready);
endinterface

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one word, compares it against the incoming word and picks its next
// value from itself, the new word, the left neighbor or the right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  spq_pkg::data_type     new_word,
   input  spq_pkg::data_type     left_word,
   input  spq_pkg::data_type     right_word,
   output spq_pkg::data_type     word,
   output logic                  ge
);
   import spq_pkg::*;

   data_type word_ff;
   data_type word_in;

   // an empty slot always yields, so the new word lands at the first free slot
   assign ge   = !ctl.occupied || (new_word >= word_ff);
   assign word = word_ff;

   always_comb begin
      word_in = word_ff;
      if (ctl.ins) begin
         if (ctl.ge_prev) begin
            word_in = left_word;
         end else if (ge) begin
            word_in = new_word;
         end
      end else if (ctl.rem) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: fixed-capacity priority queue in a chain of cells
// Keeps signed words in descending order; insert places the new word ahead of
// the first stored word it is greater than or equal to, remove pops the top.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                         accepted when
//   req_chan  in    cmd, value                      valid && ready
//   rsp_chan  out   status, removed_value, count    valid && ready
//
// every cell compares and shifts in the same cycle; the response appears in the
// output register in the cycle after the request is taken
// request ready is high whenever the output register is free or being taken,
// so a new word enters while the previous response is handed over
// reset clears the entry count and the response valid; slot contents are
// never read above the count and need no clearing
//
module sorted_priority_queue #(
   parameter int unsigned CAPACITY = 16
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);
   import spq_pkg::*;

   localparam int unsigned CntW = $clog2(CAPACITY + 1);

   // entry count
   logic [CntW-1:0] cnt_ff;
   logic [CntW-1:0] cnt_in;

   // response register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type rsp_status_ff;
   status_type rsp_status_in;
   data_type   rsp_value_ff;
   data_type   rsp_value_in;
   count_type  rsp_count_ff;
   count_type  rsp_count_in;

   // chain wiring
   data_type     cell_word [CAPACITY];
   logic         cell_ge   [CAPACITY];
   cell_ctl_type cell_ctl  [CAPACITY];

   logic req_take;
   logic is_full;
   logic is_empty;
   logic do_ins;
   logic do_rem;
   logic [CntW+CountW-1:0] cnt_ext;

   // output register frees up when the current response is taken
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign is_full  = (cnt_ff == CntW'(CAPACITY));
   assign is_empty = (cnt_ff == '0);
   assign do_ins   = req_take && (req_chan.cmd == CMD_INSERT) && !is_full;
   assign do_rem   = req_take && (req_chan.cmd == CMD_REMOVE) && !is_empty;

   // the row of cells; neighbors at the ends are don't-care words
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type left_word;
      data_type right_word;

      if (i == 0) begin : g_first
         assign left_word = req_chan.value;
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end

      always_comb begin
         cell_ctl[i].ins      = do_ins;
         cell_ctl[i].rem      = do_rem;
         cell_ctl[i].occupied = (CntW'(i) < cnt_ff);
         // ge is monotonic along the sorted row, so the left flag marks
         // the cells behind the insertion point
         cell_ctl[i].ge_prev  = (i == 0) ? 1'b0 : cell_ge[(i == 0) ? 0 : i-1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .new_word   (req_chan.value),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i]),
         .ge         (cell_ge[i])
      );
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (do_ins) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rem) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // count field reports the count modulo 32
   assign cnt_ext = {{CountW{1'b0}}, cnt_in};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = '0;
         rsp_count_in = cnt_ext[CountW-1:0];
         unique case (req_chan.cmd)
            CMD_INSERT: begin
               rsp_status_in = is_full ? ST_FULL : ST_INSERTED;
            end
            CMD_REMOVE: begin
               rsp_status_in = is_empty ? ST_EMPTY : ST_REMOVED;
               if (!is_empty) begin
                  rsp_value_in = cell_word[0];
               end
            end
            default: begin
               rsp_status_in = ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.removed_value = rsp_value_ff;
   assign rsp_chan.count         = rsp_count_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // entry count stays within capacity
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(CAPACITY))
      else $error("entry count above capacity");

   // every accepted word produces a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted word without response");

   // the two front slots stay in descending order
   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= CntW'(2)) |-> (cell_word[0] >= cell_word[1]))
      else $error("front of queue out of order");

   // a rejected insert leaves the count unchanged
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_chan.cmd == CMD_INSERT && is_full) |=> (cnt_ff == $past(cnt_ff)))
      else $error("full insert changed the count");

endmodule
